// ===== src/tis_pkg.sv =====
`default_nettype none
package tis_pkg;

   // default sizes
   localparam int MEM_WORDS_DEF   = 4096;
   localparam int STACK_DEPTH_DEF = 16;

   // status codes
   localparam logic [2:0] STAT_OK       = 3'd0;
   localparam logic [2:0] STAT_END      = 3'd1;
   localparam logic [2:0] STAT_PROG_END = 3'd2;
   localparam logic [2:0] STAT_BAD_OP   = 3'd3;
   localparam logic [2:0] STAT_DIV_ZERO = 3'd4;
   localparam logic [2:0] STAT_STACK_OV = 3'd5;

   // item kinds
   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_STEP = 1'b1;

   // instruction categories
   localparam logic [3:0] CAT_MEM   = 4'd0;
   localparam logic [3:0] CAT_ARITH = 4'd1;
   localparam logic [3:0] CAT_JUMP  = 4'd2;
   localparam logic [3:0] CAT_LOGIC = 4'd3;
   localparam logic [3:0] CAT_SHIFT = 4'd4;
   localparam logic [3:0] CAT_CMP   = 4'd5;

   // memory ops
   localparam logic [3:0] OP_LDI = 4'd0;
   localparam logic [3:0] OP_LD  = 4'd1;
   localparam logic [3:0] OP_ST  = 4'd2;
   localparam logic [3:0] OP_STI = 4'd3;
   localparam logic [3:0] OP_LDA = 4'd4;
   // arithmetic ops
   localparam logic [3:0] OP_ADD = 4'd0;
   localparam logic [3:0] OP_SUB = 4'd1;
   localparam logic [3:0] OP_MUL = 4'd2;
   localparam logic [3:0] OP_DIV = 4'd3;
   // jump ops
   localparam logic [3:0] OP_JMP    = 4'd0;
   localparam logic [3:0] OP_JR     = 4'd1;
   localparam logic [3:0] OP_BNZ    = 4'd2;
   localparam logic [3:0] OP_JRNZ   = 4'd3;
   localparam logic [3:0] OP_RET    = 4'd4;
   localparam logic [3:0] OP_HALT   = 4'd5;
   localparam logic [3:0] OP_CALL   = 4'd6;
   localparam logic [3:0] OP_CALLNZ = 4'd7;
   // logic ops
   localparam logic [3:0] OP_AND  = 4'd0;
   localparam logic [3:0] OP_OR   = 4'd1;
   localparam logic [3:0] OP_NAND = 4'd2;
   localparam logic [3:0] OP_NOR  = 4'd3;
   localparam logic [3:0] OP_XOR  = 4'd4;
   // shift ops
   localparam logic [3:0] OP_SHL = 4'd0;
   localparam logic [3:0] OP_SHR = 4'd1;
   // compare ops
   localparam logic [3:0] OP_LT = 4'd0;
   localparam logic [3:0] OP_LE = 4'd1;
   localparam logic [3:0] OP_GT = 4'd2;
   localparam logic [3:0] OP_GE = 4'd3;
   localparam logic [3:0] OP_EQ = 4'd4;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_START,
      ST_DECODE,
      ST_READ_A,
      ST_READ_B,
      ST_READ_D,
      ST_DIV,
      ST_EXEC
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic clear;
      logic take;
      logic early;
      logic fetch;
      logic latch_ins;
      logic latch_a;
      logic latch_b;
      logic latch_d;
      logic div_start;
      logic commit;
   } tis_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic early;
      logic need_div;
      logic rsp_busy;
      logic clear_last;
      logic div_done;
   } tis_stat_type;

endpackage
`default_nettype wire

// ===== src/tis_ram.sv =====
`default_nettype none
module tis_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire                         clock,
   input  wire                         we,
   input  wire [(DEPTH>1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire [WIDTH-1:0]             wdata,
   input  wire                         re,
   input  wire [(DEPTH>1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]            rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end
endmodule
`default_nettype wire

// ===== src/tis_div.sv =====
`default_nettype none
module tis_div
   import tis_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   input  wire         start,
   input  wire  [31:0] dividend,
   input  wire  [31:0] divisor,
   output logic        done,
   output logic [31:0] quotient
);
   logic [31:0] rem_ff, rem_in;
   logic [31:0] quot_ff, quot_in;
   logic [31:0] dvs_ff;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [32:0] shifted;
   logic [33:0] diff;

   // one quotient bit per cycle, restoring
   always_comb begin
      shifted = {rem_ff, quot_ff[31]};
      diff    = {1'b0, shifted} - {2'b00, dvs_ff};
      rem_in  = rem_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         rem_in  = '0;
         quot_in = dividend;
         cnt_in  = '0;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         if (!diff[33]) begin
            rem_in  = diff[31:0];
            quot_in = {quot_ff[30:0], 1'b1};
         end else begin
            rem_in  = shifted[31:0];
            quot_in = {quot_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      if (start) begin
         dvs_ff <= divisor;
      end
   end

   assign done     = done_ff;
   assign quotient = quot_ff;
endmodule
`default_nettype wire

// ===== src/tis_ctrl.sv =====
`default_nettype none
module tis_ctrl
   import tis_pkg::*;
(
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   input  tis_stat_type st,
   output tis_cmd_type  cmd
);
   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (st.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.take = 1'b1;
               state_in = ST_START;
            end
         end
         ST_START: begin
            if (!st.early) begin
               cmd.fetch = 1'b1;
               state_in  = ST_DECODE;
            end else if (!st.rsp_busy) begin
               cmd.early = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         ST_DECODE: begin
            cmd.latch_ins = 1'b1;
            state_in      = ST_READ_A;
         end
         ST_READ_A: begin
            cmd.latch_a = 1'b1;
            state_in    = ST_READ_B;
         end
         ST_READ_B: begin
            cmd.latch_b = 1'b1;
            state_in    = ST_READ_D;
         end
         ST_READ_D: begin
            cmd.latch_d = 1'b1;
            if (st.need_div) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV;
            end else begin
               state_in = ST_EXEC;
            end
         end
         ST_DIV: begin
            if (st.div_done) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (!st.rsp_busy) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end
endmodule
`default_nettype wire

// ===== src/tis_dp.sv =====
`default_nettype none
module tis_dp
   import tis_pkg::*;
#(
   parameter int MEM_WORDS   = MEM_WORDS_DEF,
   parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
   input  wire          clock,
   input  wire          reset,
   input  tis_cmd_type  cmd,
   output tis_stat_type st,
   input  wire          item_kind,
   input  wire  [11:0]  item_load_address,
   input  wire  [31:0]  item_load_word,
   input  wire          csr_we,
   input  wire  [31:0]  csr_wdata,
   input  wire          rsp_tready,
   output logic         rsp_tvalid,
   output logic [127:0] rsp_tdata
);
   localparam int MAW = $clog2(MEM_WORDS);
   localparam int SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int SCW = $clog2(STACK_DEPTH + 1);

   // item and architectural state
   logic        kind_ff;
   logic [11:0] laddr_ff;
   logic [31:0] lword_ff;
   logic [31:0] prog_end_ff;
   logic [31:0] pc_ff;
   logic [SCW-1:0] sp_ff;
   logic        halted_ff;
   logic [2:0]  halt_code_ff;
   logic [MAW-1:0] clr_ff;
   logic [31:0] ins_ff, a_ff, b_ff, d_ff;
   logic [255:0] rf_vld_ff;
   logic        rf_vq_ff;

   // result register
   logic        rsp_valid_ff;
   logic [31:0] rsp_pc_ff;
   logic [2:0]  rsp_status_ff;
   logic        rsp_rw_ff;
   logic [7:0]  rsp_ri_ff;
   logic [31:0] rsp_rv_ff;
   logic        rsp_mw_ff;
   logic [11:0] rsp_ma_ff;
   logic [31:0] rsp_mv_ff;

   // memories
   logic           mem_we, mem_re;
   logic [MAW-1:0] mem_waddr, mem_raddr;
   logic [31:0]    mem_wdata, mem_rdata;
   logic           rf_we, rf_re;
   logic [7:0]     rf_waddr, rf_raddr;
   logic [31:0]    rf_rdata, rf_val;
   logic           stk_we;
   logic [SAW-1:0] stk_waddr, stk_raddr;
   logic [31:0]    stk_rdata;
   logic [SCW-1:0] sp_m1;

   // divider
   logic        div_done;
   logic [31:0] div_q;

   // execute outcome
   logic [3:0]  cat, op;
   logic [31:0] ex_next;
   logic [2:0]  ex_status;
   logic        ex_rw, ex_mw, ex_push, ex_pop;
   logic [31:0] ex_rv, ex_mv;
   logic [MAW-1:0] ex_ma;
   logic        ex_ok;
   logic [31:0] sext24, sext16h, sext16l;
   logic [31:0] product;
   logic        stack_full;

   assign cat        = ins_ff[31:28];
   assign op         = ins_ff[27:24];
   assign sext24     = {{8{ins_ff[23]}}, ins_ff[23:0]};
   assign sext16h    = {{16{ins_ff[23]}}, ins_ff[23:8]};
   assign sext16l    = {{16{ins_ff[15]}}, ins_ff[15:0]};
   assign product    = a_ff * b_ff;
   assign stack_full = (sp_ff >= SCW'(STACK_DEPTH));
   assign sp_m1      = sp_ff - 1'b1;
   assign rf_val     = rf_vq_ff ? rf_rdata : 32'd0;

   // status to the controller
   assign st.early      = (kind_ff == KIND_LOAD) || halted_ff || (pc_ff == prog_end_ff);
   assign st.need_div   = (cat == CAT_ARITH) && (op == OP_DIV) && (b_ff != 32'd0);
   assign st.rsp_busy   = rsp_valid_ff && !rsp_tready;
   assign st.clear_last = (clr_ff == {MAW{1'b1}});
   assign st.div_done   = div_done;

   // instruction decode and execute
   always_comb begin
      ex_next   = pc_ff + 32'd4;
      ex_status = STAT_OK;
      ex_rw     = 1'b0;
      ex_rv     = '0;
      ex_mw     = 1'b0;
      ex_ma     = '0;
      ex_mv     = '0;
      ex_push   = 1'b0;
      ex_pop    = 1'b0;
      unique case (cat)
         CAT_MEM: begin
            unique case (op)
               OP_LDI: begin ex_rw = 1'b1; ex_rv = sext16l; end
               OP_LD:  begin ex_rw = 1'b1; ex_rv = mem_rdata; end
               OP_ST:  begin ex_mw = 1'b1; ex_ma = d_ff[MAW-1:0]; ex_mv = a_ff; end
               OP_STI: begin ex_mw = 1'b1; ex_ma = MAW'(ins_ff[23:8]); ex_mv = b_ff; end
               OP_LDA: begin ex_rw = 1'b1; ex_rv = mem_rdata; end
               default: ex_status = STAT_BAD_OP;
            endcase
         end
         CAT_ARITH: begin
            unique case (op)
               OP_ADD: begin ex_rw = 1'b1; ex_rv = a_ff + b_ff; end
               OP_SUB: begin ex_rw = 1'b1; ex_rv = a_ff - b_ff; end
               OP_MUL: begin ex_rw = 1'b1; ex_rv = product; end
               OP_DIV: begin
                  if (b_ff == 32'd0) begin
                     ex_status = STAT_DIV_ZERO;
                  end else begin
                     ex_rw = 1'b1;
                     ex_rv = div_q;
                  end
               end
               default: ex_status = STAT_BAD_OP;
            endcase
         end
         CAT_JUMP: begin
            unique case (op)
               OP_JMP: ex_next = pc_ff + sext24;
               OP_JR:  ex_next = pc_ff + d_ff;
               OP_BNZ: begin
                  if (b_ff != 32'd0) ex_next = pc_ff + sext16h;
               end
               OP_JRNZ: begin
                  if (b_ff != 32'd0) ex_next = pc_ff + d_ff;
               end
               OP_RET: begin
                  if (sp_ff != '0) begin
                     ex_pop  = 1'b1;
                     ex_next = stk_rdata;
                  end
               end
               OP_HALT: ex_status = STAT_END;
               OP_CALL: begin
                  if (stack_full) begin
                     ex_status = STAT_STACK_OV;
                  end else begin
                     ex_push = 1'b1;
                     ex_next = pc_ff + sext24;
                  end
               end
               OP_CALLNZ: begin
                  if (b_ff != 32'd0) begin
                     if (stack_full) begin
                        ex_status = STAT_STACK_OV;
                     end else begin
                        ex_push = 1'b1;
                        ex_next = pc_ff + sext16h;
                     end
                  end
               end
               default: ex_status = STAT_BAD_OP;
            endcase
         end
         CAT_LOGIC: begin
            unique case (op)
               OP_AND:  begin ex_rw = 1'b1; ex_rv = a_ff & b_ff; end
               OP_OR:   begin ex_rw = 1'b1; ex_rv = a_ff | b_ff; end
               OP_NAND: begin ex_rw = 1'b1; ex_rv = ~(a_ff & b_ff); end
               OP_NOR:  begin ex_rw = 1'b1; ex_rv = ~(a_ff | b_ff); end
               OP_XOR:  begin ex_rw = 1'b1; ex_rv = a_ff ^ b_ff; end
               default: ex_status = STAT_BAD_OP;
            endcase
         end
         CAT_SHIFT: begin
            // unknown shift is a no-op
            if (op == OP_SHL) begin
               ex_rw = 1'b1;
               ex_rv = (b_ff[31:5] != '0) ? 32'd0 : (a_ff << b_ff[4:0]);
            end else if (op == OP_SHR) begin
               ex_rw = 1'b1;
               ex_rv = (b_ff[31:5] != '0) ? 32'd0 : (a_ff >> b_ff[4:0]);
            end
         end
         CAT_CMP: begin
            // unknown compare is a no-op
            ex_rw = 1'b1;
            unique case (op)
               OP_LT: ex_rv = {31'd0, $signed(a_ff) <  $signed(b_ff)};
               OP_LE: ex_rv = {31'd0, $signed(a_ff) <= $signed(b_ff)};
               OP_GT: ex_rv = {31'd0, $signed(a_ff) >  $signed(b_ff)};
               OP_GE: ex_rv = {31'd0, $signed(a_ff) >= $signed(b_ff)};
               OP_EQ: ex_rv = {31'd0, a_ff == b_ff};
               default: ex_rw = 1'b0;
            endcase
         end
         default: ex_status = STAT_BAD_OP;
      endcase
   end

   assign ex_ok = (ex_status == STAT_OK);

   // word memory ports
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = ex_ma;
      mem_wdata = ex_mv;
      if (cmd.clear) begin
         mem_we    = 1'b1;
         mem_waddr = clr_ff;
         mem_wdata = '0;
      end else if (cmd.early && (kind_ff == KIND_LOAD)) begin
         mem_we    = 1'b1;
         mem_waddr = MAW'(laddr_ff);
         mem_wdata = lword_ff;
      end else if (cmd.commit && ex_ok && ex_mw) begin
         mem_we = 1'b1;
      end
      mem_re = cmd.fetch || cmd.latch_d;
      if (cmd.fetch) begin
         mem_raddr = pc_ff[MAW-1:0];
      end else if (op == OP_LD) begin
         mem_raddr = a_ff[MAW-1:0];
      end else begin
         mem_raddr = MAW'(ins_ff[15:0]);
      end
   end

   // register file ports: rs1, rs2, rd read in turn
   assign rf_re    = cmd.latch_ins || cmd.latch_a || cmd.latch_b;
   assign rf_raddr = cmd.latch_ins ? mem_rdata[15:8] :
                     cmd.latch_a   ? ins_ff[7:0]     : ins_ff[23:16];
   assign rf_we    = cmd.commit && ex_ok && ex_rw;
   assign rf_waddr = ins_ff[23:16];

   // return stack ports
   assign stk_we    = cmd.commit && ex_ok && ex_push;
   assign stk_waddr = sp_ff[SAW-1:0];
   assign stk_raddr = sp_m1[SAW-1:0];

   tis_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   tis_ram #(.WIDTH(32), .DEPTH(256)) u_rf (
      .clock (clock),
      .we    (rf_we),
      .waddr (rf_waddr),
      .wdata (ex_rv),
      .re    (rf_re),
      .raddr (rf_raddr),
      .rdata (rf_rdata)
   );

   tis_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack (
      .clock (clock),
      .we    (stk_we),
      .waddr (stk_waddr),
      .wdata (pc_ff + 32'd4),
      .re    (cmd.latch_d),
      .raddr (stk_raddr),
      .rdata (stk_rdata)
   );

   tis_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (a_ff),
      .divisor  (b_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         prog_end_ff   <= '0;
         pc_ff         <= '0;
         sp_ff         <= '0;
         halted_ff     <= 1'b0;
         halt_code_ff  <= STAT_OK;
         clr_ff        <= '0;
         rf_vld_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            prog_end_ff <= csr_wdata;
         end
         if (cmd.clear) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         // early outcome: load, halted or program end
         if (cmd.early) begin
            rsp_valid_ff <= 1'b1;
            if ((kind_ff == KIND_STEP) && !halted_ff) begin
               halted_ff    <= 1'b1;
               halt_code_ff <= STAT_PROG_END;
            end
         end
         // instruction retire
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
            if (!ex_ok) begin
               halted_ff    <= 1'b1;
               halt_code_ff <= ex_status;
            end else begin
               pc_ff <= ex_next;
               if (ex_push) sp_ff <= sp_ff + 1'b1;
               if (ex_pop)  sp_ff <= sp_m1;
               if (ex_rw)   rf_vld_ff[rf_waddr] <= 1'b1;
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         kind_ff  <= item_kind;
         laddr_ff <= item_load_address;
         lword_ff <= item_load_word;
      end
      if (rf_re) begin
         rf_vq_ff <= rf_vld_ff[rf_raddr];
      end
      if (cmd.latch_ins) ins_ff <= mem_rdata;
      if (cmd.latch_a)   a_ff   <= rf_val;
      if (cmd.latch_b)   b_ff   <= rf_val;
      if (cmd.latch_d)   d_ff   <= rf_val;
      if (cmd.early) begin
         rsp_pc_ff <= pc_ff;
         rsp_rw_ff <= 1'b0;
         rsp_ri_ff <= '0;
         rsp_rv_ff <= '0;
         rsp_mw_ff <= 1'b0;
         rsp_ma_ff <= '0;
         rsp_mv_ff <= '0;
         if (halted_ff) begin
            rsp_status_ff <= halt_code_ff;
         end else if (kind_ff == KIND_LOAD) begin
            rsp_status_ff <= STAT_OK;
         end else begin
            rsp_status_ff <= STAT_PROG_END;
         end
      end
      if (cmd.commit) begin
         rsp_status_ff <= ex_status;
         rsp_pc_ff     <= ex_ok ? ex_next : pc_ff;
         rsp_rw_ff     <= ex_ok && ex_rw;
         rsp_ri_ff     <= (ex_ok && ex_rw) ? ins_ff[23:16] : 8'd0;
         rsp_rv_ff     <= (ex_ok && ex_rw) ? ex_rv : 32'd0;
         rsp_mw_ff     <= ex_ok && ex_mw;
         rsp_ma_ff     <= (ex_ok && ex_mw) ? 12'(ex_ma) : 12'd0;
         rsp_mv_ff     <= (ex_ok && ex_mw) ? ex_mv : 32'd0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_mv_ff, rsp_ma_ff, rsp_mw_ff, rsp_rv_ff, rsp_ri_ff,
                        rsp_rw_ff, rsp_status_ff, rsp_pc_ff};
endmodule
`default_nettype wire

// ===== src/toy_isa_execute_step.sv =====
`default_nettype none
// channel  | direction | tdata fields (low bit up)                          | tuser
// req      | in        | load_address[11:0], load_word[43:12]               | kind
// rsp      | out       | program_counter, status, reg_written, reg_index,   | -
//          |           | reg_value, mem_written, mem_address, mem_value     |
// csr      | in        | program_end (write enable plus data)               | -
//
// load item: the word is written and its result registered in ST_START
// step item: result registered after fetch, decode, three register file reads
// and execute; a divide by a nonzero divisor waits in ST_DIV before execute
// for the bit-serial divider; halted or program-end steps end in ST_START
// after reset the word memory is cleared, with req_tready low until it is done
// one item at a time; a waiting result holds the next item before its result
module toy_isa_execute_step
   import tis_pkg::*;
#(
   parameter int MEM_WORDS   = MEM_WORDS_DEF,
   parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   input  wire  [47:0]  req_tdata,   // load_address[11:0], load_word[43:12]
   input  wire          req_tuser,   // kind
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   output logic [127:0] rsp_tdata,   // pc[31:0], status[34:32], reg_written[35],
                                     // reg_index[43:36], reg_value[75:44],
                                     // mem_written[76], mem_address[88:77],
                                     // mem_value[120:89]
   input  wire          csr_we,
   input  wire  [31:0]  csr_wdata
);
   tis_cmd_type  cmd;
   tis_stat_type st;

   tis_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .st         (st),
      .cmd        (cmd)
   );

   tis_dp #(.MEM_WORDS(MEM_WORDS), .STACK_DEPTH(STACK_DEPTH)) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .st                (st),
      .item_kind         (req_tuser),
      .item_load_address (req_tdata[11:0]),
      .item_load_word    (req_tdata[43:12]),
      .csr_we            (csr_we),
      .csr_wdata         (csr_wdata),
      .rsp_tready        (rsp_tready),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_tdata         (rsp_tdata)
   );

   // status code stays in range
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[34:32] <= STAT_STACK_OV))
      else $error("status out of range");

   // no register write reported means zero register fields
   a_reg_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tdata[35]) |-> (rsp_tdata[75:36] == '0))
      else $error("register fields set without a write");

   // one item at a time
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second item taken while busy");
endmodule
`default_nettype wire
